FILE: rtl/core/cos_pkg.sv
// ----------------------------------------------------------------------------
// cos_pkg
// Shared types, constants and bit-search helpers for the circular occupancy
// search block.
// ----------------------------------------------------------------------------
package cos_pkg;

  localparam int MAX_LANE_CELLS = 2048;
  localparam int LANE_COUNT     = 2;
  localparam int WORD_BITS      = 64;
  localparam int STORE_WORDS    = (LANE_COUNT * MAX_LANE_CELLS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W         = $clog2(STORE_WORDS);
  localparam int OFS_W          = $clog2(WORD_BITS);
  localparam int BIT_W          = ADDR_W + OFS_W;
  localparam int POS_W          = 11;
  localparam int LEN_W          = 12;

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LANE_CELLS);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(2048);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef logic [1:0] func_t;
  localparam func_t FN_CLEAR = 2'd0;
  localparam func_t FN_MARK  = 2'd1;
  localparam func_t FN_FWD   = 2'd2;
  localparam func_t FN_BWD   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MARK_WR,
    ST_SEG,
    ST_SCAN,
    ST_RESP
  } state_t;

  // One contiguous stretch of absolute store bits, inclusive bounds.
  typedef struct packed {
    logic             empty;
    logic [BIT_W-1:0] lo;
    logic [BIT_W-1:0] hi;
  } seg_t;

  // Offset of the lowest set bit of a word.
  function automatic logic [OFS_W-1:0] lowest_set(input word_t v);
    logic [OFS_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = OFS_W'(i);
    end
    return idx;
  endfunction

  // Offset of the highest set bit of a word.
  function automatic logic [OFS_W-1:0] highest_set(input word_t v);
    logic [OFS_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) idx = OFS_W'(i);
    end
    return idx;
  endfunction

endpackage

FILE: rtl/core/circular_occupancy_search.sv
// ----------------------------------------------------------------------------
// circular_occupancy_search
// Occupancy bit store of two circular lanes with forward and backward
// wrap-around search for the nearest occupied cell.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Word contents
//  in_      in   tvalid / tready    tuser: func, lane; tdata: position
//  out_     out  tvalid / tready    tuser: found; tdata: hit_position
//  cfg_     in   we                 wdata: lane_length
//
// A clear goes straight to the result state. A mark reads the word that holds
// the cell, writes it back with the cell set and then loads its result; a
// search or mark that is turned away goes from setup to the result state. A
// search that scans has a setup step, then for each part of the lane (above
// and below the start cell) a step to start it, a read of each 64-bit store
// word and a step to examine the last word, and a final step to load the
// result. An empty part costs its start step only. The two parts of a
// 2048-cell lane read at most 33 words through the store's single read port.
// The block takes no new word until the previous result has been loaded into
// the output register; a stalled output holds its word and keeps the block
// waiting in its result state. Reset clears the whole store at once through
// one valid bit per store word and sets lane_length to 2048.
//
module circular_occupancy_search
  import cos_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,      // [11:0] lane_length
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,       // [10:0] position, [15:11] zero
  input  logic [2:0]  in_tuser,       // [1:0] func, [2] lane
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,      // [10:0] hit_position, [15:11] zero
  output logic        out_tuser       // [0] found
);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  len_r;
  func_t             func_r, func_nxt;
  logic              lane_r, lane_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  seg_t              seg0_r, seg0_nxt;
  seg_t              seg1_r, seg1_nxt;
  logic              seg_sel_r, seg_sel_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;        // next word to read, or word to mark
  logic [ADDR_W-1:0] end_w_r, end_w_nxt;    // last word of the current segment
  logic              iss_r, iss_nxt;        // reads still being issued
  logic              ev_vld_r, ev_vld_nxt;  // read data is to be examined
  logic [ADDR_W-1:0] ev_w_r, ev_w_nxt;      // word index of the read data
  logic              ev_last_r, ev_last_nxt;
  logic [OFS_W-1:0]  mark_ofs_r, mark_ofs_nxt;
  logic              res_found_r, res_found_nxt;
  logic [POS_W-1:0]  res_hit_r, res_hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [POS_W-1:0]  out_hit_r, out_hit_nxt;
  logic [STORE_WORDS-1:0] wvld_r, wvld_nxt; // store word holds written data

  // Store memory and its registered read port.
  word_t             mem [STORE_WORDS];
  word_t             rd_data_r;
  logic              rd_wvld_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  word_t             wr_data;

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic              in_acc;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  base;
  logic [LEN_W-1:0]  pos_ext;
  logic              pos_ok;
  logic [BIT_W-1:0]  base_pos;
  seg_t              seg_up, seg_dn, cur;
  logic              dir_up;
  word_t             word_eff, lo_mask, hi_mask, cand;
  logic [OFS_W-1:0]  hit_ofs;
  logic [BIT_W-1:0]  hit_abs;
  logic [BIT_W-1:0]  hit_rel;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Lane lengths above the store's lane capacity saturate.
  assign len_eff  = (len_r > LEN_MAX) ? LEN_MAX : len_r;
  assign base     = lane_r ? len_eff : '0;
  assign pos_ext  = LEN_W'(pos_r);
  assign pos_ok   = (pos_ext < len_eff);
  assign base_pos = BIT_W'(base + pos_ext);
  assign dir_up   = (func_r == FN_FWD);

  // Cells above the start position, and cells below it, as absolute bits.
  always_comb begin
    seg_up.empty = (pos_ext == len_eff - LEN_W'(1));
    seg_up.lo    = base_pos + BIT_W'(1);
    seg_up.hi    = BIT_W'(base + len_eff - LEN_W'(1));
    seg_dn.empty = (pos_r == '0);
    seg_dn.lo    = BIT_W'(base);
    seg_dn.hi    = base_pos - BIT_W'(1);
  end

  assign cur = seg_sel_r ? seg1_r : seg0_r;

  // Examine the word read in the previous cycle within the segment bounds.
  always_comb begin
    word_eff = rd_wvld_r ? rd_data_r : '0;
    lo_mask  = (ev_w_r == cur.lo[BIT_W-1:OFS_W]) ? ('1 << cur.lo[OFS_W-1:0]) : '1;
    hi_mask  = (ev_w_r == cur.hi[BIT_W-1:OFS_W]) ? ('1 >> (~cur.hi[OFS_W-1:0])) : '1;
    cand     = word_eff & lo_mask & hi_mask;
    hit_ofs  = dir_up ? lowest_set(cand) : highest_set(cand);
    hit_abs  = {ev_w_r, hit_ofs};
    hit_rel  = hit_abs - BIT_W'(base);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    lane_nxt      = lane_r;
    pos_nxt       = pos_r;
    seg0_nxt      = seg0_r;
    seg1_nxt      = seg1_r;
    seg_sel_nxt   = seg_sel_r;
    ptr_nxt       = ptr_r;
    end_w_nxt     = end_w_r;
    iss_nxt       = iss_r;
    ev_vld_nxt    = 1'b0;
    ev_w_nxt      = ev_w_r;
    ev_last_nxt   = ev_last_r;
    mark_ofs_nxt  = mark_ofs_r;
    res_found_nxt = res_found_r;
    res_hit_nxt   = res_hit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_hit_nxt   = out_hit_r;
    wvld_nxt      = wvld_r;
    rd_addr       = ptr_r;
    wr_en         = 1'b0;
    wr_data       = word_eff | (word_t'(1) << mark_ofs_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          func_nxt      = in_tuser[1:0];
          lane_nxt      = in_tuser[2];
          pos_nxt       = in_tdata[POS_W-1:0];
          res_found_nxt = 1'b0;
          res_hit_nxt   = '0;
          if (in_tuser[1:0] == FN_CLEAR) begin
            wvld_nxt  = '0;
            state_nxt = ST_RESP;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end

      ST_SETUP: begin
        if (func_r == FN_MARK) begin
          // Read the word that holds the cell; the write follows.
          rd_addr      = base_pos[BIT_W-1:OFS_W];
          ptr_nxt      = base_pos[BIT_W-1:OFS_W];
          mark_ofs_nxt = base_pos[OFS_W-1:0];
          state_nxt    = pos_ok ? ST_MARK_WR : ST_RESP;
        end else if (pos_ok && (len_eff > LEN_W'(1))) begin
          // Forward: above the start, then wrap to below it.
          // Backward: below the start going down, then wrap to the top.
          seg0_nxt    = dir_up ? seg_up : seg_dn;
          seg1_nxt    = dir_up ? seg_dn : seg_up;
          seg_sel_nxt = 1'b0;
          state_nxt   = ST_SEG;
        end else begin
          state_nxt = ST_RESP;
        end
      end

      ST_MARK_WR: begin
        wr_en            = 1'b1;
        wvld_nxt[ptr_r]  = 1'b1;
        state_nxt        = ST_RESP;
      end

      ST_SEG: begin
        if (cur.empty) begin
          if (seg_sel_r) begin
            state_nxt = ST_RESP;
          end else begin
            seg_sel_nxt = 1'b1;
          end
        end else begin
          ptr_nxt   = dir_up ? cur.lo[BIT_W-1:OFS_W] : cur.hi[BIT_W-1:OFS_W];
          end_w_nxt = dir_up ? cur.hi[BIT_W-1:OFS_W] : cur.lo[BIT_W-1:OFS_W];
          iss_nxt   = 1'b1;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle while the previous word is examined.
        if (iss_r) begin
          rd_addr     = ptr_r;
          ev_vld_nxt  = 1'b1;
          ev_w_nxt    = ptr_r;
          ev_last_nxt = (ptr_r == end_w_r);
          iss_nxt     = (ptr_r != end_w_r);
          ptr_nxt     = dir_up ? ptr_r + ADDR_W'(1) : ptr_r - ADDR_W'(1);
        end
        if (ev_vld_r) begin
          if (|cand) begin
            res_found_nxt = 1'b1;
            res_hit_nxt   = hit_rel[POS_W-1:0];
            ev_vld_nxt    = 1'b0;
            iss_nxt       = 1'b0;
            state_nxt     = ST_RESP;
          end else if (ev_last_r) begin
            ev_vld_nxt = 1'b0;
            iss_nxt    = 1'b0;
            if (seg_sel_r) begin
              state_nxt = ST_RESP;
            end else begin
              seg_sel_nxt = 1'b1;
              state_nxt   = ST_SEG;
            end
          end
        end
      end

      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_hit_nxt   = res_hit_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= LEN_RESET;
      iss_r       <= 1'b0;
      ev_vld_r    <= 1'b0;
      seg_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
      wvld_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) len_r <= cfg_wdata;
      iss_r       <= iss_nxt;
      ev_vld_r    <= ev_vld_nxt;
      seg_sel_r   <= seg_sel_nxt;
      out_valid_r <= out_valid_nxt;
      wvld_r      <= wvld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    lane_r      <= lane_nxt;
    pos_r       <= pos_nxt;
    seg0_r      <= seg0_nxt;
    seg1_r      <= seg1_nxt;
    ptr_r       <= ptr_nxt;
    end_w_r     <= end_w_nxt;
    ev_w_r      <= ev_w_nxt;
    ev_last_r   <= ev_last_nxt;
    mark_ofs_r  <= mark_ofs_nxt;
    res_found_r <= res_found_nxt;
    res_hit_r   <= res_hit_nxt;
    out_found_r <= out_found_nxt;
    out_hit_r   <= out_hit_nxt;
  end

  // Store memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) mem[ptr_r] <= wr_data;
    rd_data_r <= mem[rd_addr];
    rd_wvld_r <= wvld_r[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {(16 - POS_W)'(0), out_hit_r};

endmodule
